FILE: rtl/core/wrs_pkg.sv
// Shared types and constants for the weight resampler with ESS check.
// Used by wrs_mul_unit and weight_resampler_with_ess_check; no dependencies.
`timescale 1ns / 1ps

package wrs_pkg;

  localparam int MAX_PARTICLES = 1024;
  localparam int FRACTION_BITS = 16;
  localparam int IDX_W   = $clog2(MAX_PARTICLES);
  localparam int CNT_W   = IDX_W + 1;
  localparam int W_W     = 17;
  localparam int SUM_W   = W_W + IDX_W;
  localparam int SQ_W    = 2 * W_W + IDX_W;
  localparam int SQ_HALF = (SQ_W + 1) / 2;
  localparam int OPD_W   = SUM_W;
  localparam int PROD_W  = 2 * OPD_W;
  localparam int TGT_W   = W_W + SUM_W;
  localparam int LHS_W   = 2 * SUM_W + 1;
  localparam int RLO_W   = CNT_W + SQ_HALF;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  typedef enum logic [1:0] {
    ST_SELECTED  = 2'd0,
    ST_RESAMPLE  = 2'd1,
    ST_ZERO_SUM  = 2'd2,
    ST_EFFICIENT = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_W_SQ,
    MUL_SUM_SQ,
    MUL_CNT_LO,
    MUL_CNT_HI,
    MUL_U_SUM
  } mul_sel_t;

  typedef struct packed {
    logic             operation;
    logic [W_W-1:0]   weight;
    logic [W_W-1:0]   uniform;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] selected_index;
    logic [1:0]       status;
  } out_item_t;

endpackage

FILE: rtl/core/wrs_mul_unit.sv
// Shared multiplier with operand select and a registered product.
// Depends on wrs_pkg for widths and the select codes.
`timescale 1ns / 1ps

module wrs_mul_unit (
  input  logic                       clk,
  input  wrs_pkg::mul_sel_t          sel,
  input  logic [wrs_pkg::W_W-1:0]    weight,
  input  logic [wrs_pkg::W_W-1:0]    uniform,
  input  logic [wrs_pkg::SUM_W-1:0]  weight_sum,
  input  logic [wrs_pkg::CNT_W-1:0]  loaded_count,
  input  logic [wrs_pkg::SQ_W-1:0]   square_sum,
  output logic [wrs_pkg::PROD_W-1:0] prod_r
);

  logic [wrs_pkg::OPD_W-1:0] opa;
  logic [wrs_pkg::OPD_W-1:0] opb;

  always_comb begin
    opa = '0;
    opb = '0;
    case (sel)
      wrs_pkg::MUL_W_SQ: begin
        opa = wrs_pkg::OPD_W'(weight);
        opb = wrs_pkg::OPD_W'(weight);
      end
      wrs_pkg::MUL_SUM_SQ: begin
        opa = wrs_pkg::OPD_W'(weight_sum);
        opb = wrs_pkg::OPD_W'(weight_sum);
      end
      wrs_pkg::MUL_CNT_LO: begin
        opa = wrs_pkg::OPD_W'(loaded_count);
        opb = wrs_pkg::OPD_W'(square_sum[wrs_pkg::SQ_HALF-1:0]);
      end
      wrs_pkg::MUL_CNT_HI: begin
        opa = wrs_pkg::OPD_W'(loaded_count);
        opb = wrs_pkg::OPD_W'(square_sum[wrs_pkg::SQ_W-1:wrs_pkg::SQ_HALF]);
      end
      wrs_pkg::MUL_U_SUM: begin
        opa = wrs_pkg::OPD_W'(uniform);
        opb = wrs_pkg::OPD_W'(weight_sum);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  // Hold the product while no multiply is requested.
  always_ff @(posedge clk) begin
    if (sel != wrs_pkg::MUL_NONE) begin
      prod_r <= wrs_pkg::PROD_W'(opa) * wrs_pkg::PROD_W'(opb);
    end
  end

endmodule

FILE: rtl/core/weight_resampler_with_ess_check.sv
// Top level of the weight resampler with effective-sample-size check.
// Depends on wrs_pkg and wrs_mul_unit.
//
// Usage: the input channel (in_valid/in_stall/in_data) takes load and draw
// items; the output channel (out_valid/out_stall/out_data) returns reports
// and selected indexes. A load writes the running sum into the cumulative
// memory and adds the weight and its square to the totals. A load marked
// last closes the set and returns one report (zero sum, efficient enough,
// or resample needed, which arms the block). Each armed draw returns one
// index, found by binary search of the cumulative memory, up to N draws.
// Timing: a load passes the multiply and accumulate states; a last load with
// a nonzero sum then runs the square, count and compare states up to its
// report. A draw takes the multiply, then one memory read and compare per
// search step; the memory port gives one read per cycle. One item is in work
// at a time and in_stall is high meanwhile. Results sit in an output register,
// so a new item is taken while a result waits; a finished result holds the
// sequencer until that register frees up. Reset empties the set and disarms.
`timescale 1ns / 1ps

module weight_resampler_with_ess_check (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  wrs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output wrs_pkg::out_item_t out_data
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD_MUL,
    S_LD_ACC,
    S_CL_SQ,
    S_CL_LO,
    S_CL_HI,
    S_CL_CMP,
    S_DR_MUL,
    S_DR_SRCH,
    S_EMIT
  } state_t;

  state_t                         state_r, state_nxt;
  wrs_pkg::in_item_t              item_r, item_nxt;
  logic [wrs_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic [wrs_pkg::SUM_W-1:0]      ws_r, ws_nxt;
  logic [wrs_pkg::SQ_W-1:0]       sq_r, sq_nxt;
  logic                           armed_r, armed_nxt;
  logic [wrs_pkg::CNT_W-1:0]      draws_r, draws_nxt;
  logic                           closed_r, closed_nxt;
  logic [wrs_pkg::LHS_W-1:0]      lhs_r, lhs_nxt;
  logic [wrs_pkg::RLO_W-1:0]      rlo_r, rlo_nxt;
  logic [wrs_pkg::CNT_W-1:0]      lo_r, lo_nxt;
  logic [wrs_pkg::CNT_W-1:0]      hi_r, hi_nxt;
  wrs_pkg::out_item_t             res_r, res_nxt;
  logic                           out_valid_r, out_valid_nxt;
  wrs_pkg::out_item_t             out_data_r, out_data_nxt;

  wrs_pkg::mul_sel_t              mul_sel;
  logic [wrs_pkg::PROD_W-1:0]     prod;

  logic [wrs_pkg::SUM_W-1:0]      cum_mem [wrs_pkg::MAX_PARTICLES];
  logic [wrs_pkg::SUM_W-1:0]      rd_data_r;
  logic [wrs_pkg::IDX_W-1:0]      rd_addr;
  logic                           mem_we;

  logic                           accept;
  logic                           full;
  logic [wrs_pkg::SUM_W-1:0]      ws_upd;
  logic [wrs_pkg::SQ_W-1:0]       sq_upd;
  logic [wrs_pkg::LHS_W-1:0]      rhs;
  logic [wrs_pkg::CNT_W:0]        mid_sum;
  logic [wrs_pkg::CNT_W:0]        nxt_sum;
  logic [wrs_pkg::CNT_W-1:0]      mid_cur;
  logic [wrs_pkg::TGT_W-1:0]      scaled_cum;
  logic                           hit;
  logic [wrs_pkg::CNT_W-1:0]      found;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign full   = (count_r >= wrs_pkg::CNT_W'(wrs_pkg::MAX_PARTICLES));
  assign ws_upd = ws_r + wrs_pkg::SUM_W'(item_r.weight);
  assign sq_upd = sq_r + wrs_pkg::SQ_W'(prod[2*wrs_pkg::W_W-1:0]);
  assign rhs    = wrs_pkg::LHS_W'(rlo_r)
                + (wrs_pkg::LHS_W'(prod[wrs_pkg::RLO_W-1:0]) << wrs_pkg::SQ_HALF);

  assign mid_sum    = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_cur    = mid_sum[wrs_pkg::CNT_W:1];
  assign scaled_cum = wrs_pkg::TGT_W'({rd_data_r, wrs_pkg::FRACTION_BITS'(0)});
  assign hit        = (scaled_cum >= prod[wrs_pkg::TGT_W-1:0]);

  assign nxt_sum = {1'b0, lo_nxt} + {1'b0, hi_nxt};
  assign rd_addr = nxt_sum[wrs_pkg::IDX_W:1];
  assign mem_we  = (state_r == S_LD_ACC) && !full;

  wrs_mul_unit u_mul (
    .clk          (clk),
    .sel          (mul_sel),
    .weight       (item_r.weight),
    .uniform      (item_r.uniform),
    .weight_sum   (ws_r),
    .loaded_count (count_r),
    .square_sum   (sq_r),
    .prod_r       (prod)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cum_mem[count_r[wrs_pkg::IDX_W-1:0]] <= ws_upd;
    end
    rd_data_r <= cum_mem[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    count_nxt     = count_r;
    ws_nxt        = ws_r;
    sq_nxt        = sq_r;
    armed_nxt     = armed_r;
    draws_nxt     = draws_r;
    closed_nxt    = closed_r;
    lhs_nxt       = lhs_r;
    rlo_nxt       = rlo_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    res_nxt       = res_r;
    found         = '0;
    mul_sel       = wrs_pkg::MUL_NONE;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          item_nxt = in_data;
          if (in_data.operation == wrs_pkg::OP_LOAD) begin
            armed_nxt = 1'b0;
            if (closed_r) begin
              count_nxt  = '0;
              ws_nxt     = '0;
              sq_nxt     = '0;
              draws_nxt  = '0;
              closed_nxt = 1'b0;
            end
            state_nxt = S_LD_MUL;
          end else if (armed_r && (count_r != '0) && (draws_r < count_r)) begin
            state_nxt = S_DR_MUL;
          end
        end
      end
      S_LD_MUL: begin
        mul_sel   = wrs_pkg::MUL_W_SQ;
        state_nxt = S_LD_ACC;
      end
      S_LD_ACC: begin
        if (!full) begin
          ws_nxt    = ws_upd;
          sq_nxt    = sq_upd;
          count_nxt = count_r + 1'b1;
        end
        if (!item_r.last) begin
          state_nxt = S_IDLE;
        end else begin
          closed_nxt = 1'b1;
          if ((full ? ws_r : ws_upd) == '0) begin
            res_nxt   = '{selected_index: '0, status: wrs_pkg::ST_ZERO_SUM};
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_CL_SQ;
          end
        end
      end
      S_CL_SQ: begin
        mul_sel   = wrs_pkg::MUL_SUM_SQ;
        state_nxt = S_CL_LO;
      end
      S_CL_LO: begin
        lhs_nxt   = {prod, 1'b0};
        mul_sel   = wrs_pkg::MUL_CNT_LO;
        state_nxt = S_CL_HI;
      end
      S_CL_HI: begin
        rlo_nxt   = prod[wrs_pkg::RLO_W-1:0];
        mul_sel   = wrs_pkg::MUL_CNT_HI;
        state_nxt = S_CL_CMP;
      end
      S_CL_CMP: begin
        if (lhs_r >= rhs) begin
          res_nxt = '{selected_index: '0, status: wrs_pkg::ST_EFFICIENT};
        end else begin
          armed_nxt = 1'b1;
          draws_nxt = '0;
          res_nxt   = '{selected_index: '0, status: wrs_pkg::ST_RESAMPLE};
        end
        state_nxt = S_EMIT;
      end
      S_DR_MUL: begin
        // Start the search over [0, count) and fetch the middle entry.
        mul_sel   = wrs_pkg::MUL_U_SUM;
        lo_nxt    = '0;
        hi_nxt    = count_r;
        state_nxt = S_DR_SRCH;
      end
      S_DR_SRCH: begin
        if (hit) begin
          hi_nxt = mid_cur;
        end else begin
          lo_nxt = mid_cur + 1'b1;
        end
        found = (lo_nxt >= count_r) ? (count_r - 1'b1) : lo_nxt;
        if (lo_nxt >= hi_nxt) begin
          draws_nxt = draws_r + 1'b1;
          res_nxt   = '{selected_index: found[wrs_pkg::IDX_W-1:0],
                        status: wrs_pkg::ST_SELECTED};
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ws_r        <= '0;
      sq_r        <= '0;
      armed_r     <= 1'b0;
      draws_r     <= '0;
      closed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ws_r        <= ws_nxt;
      sq_r        <= sq_nxt;
      armed_r     <= armed_nxt;
      draws_r     <= draws_nxt;
      closed_r    <= closed_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    lhs_r      <= lhs_nxt;
    rlo_r      <= rlo_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

FILE: bench/testbench.sv
// Self-checking bench for weight_resampler_with_ess_check: load/draw items, predicted results.
// Needs wrs_pkg and the RTL of the block; an in-bench predictor checks every transfer.
`timescale 1ns / 1ps

module testbench;

  localparam int RANDOM_ITEMS = 1850;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int SETTLE_TAIL  = 32;
  localparam logic [wrs_pkg::W_W-1:0] W_FIELD_MAX = '1;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} stall_mode_t;
  typedef enum {W_SKEWED, W_FULL, W_EQUAL, W_ZERO, W_SPARSE, W_TINY, W_EXTREME} weight_style_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  wrs_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  wrs_pkg::out_item_t out_data;

  // Predictor state
  longint unsigned cum_sums [wrs_pkg::MAX_PARTICLES];
  int unsigned     stored_weights;
  longint unsigned total_weight;
  longint unsigned total_square;
  bit              resample_armed;
  int unsigned     draw_count;
  bit              set_closed;

  wrs_pkg::out_item_t pending_results [$];
  int                 error_count = 0;
  int                 cycle_count = 0;
  int                 counted_items = 0;
  int                 burst_left = 0;
  stall_mode_t        stall_mode = STALL_NONE;
  int                 stall_run = 0;

  weight_resampler_with_ess_check u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("weight_resampler_with_ess_check regression: fail");
      $finish;
    end
  end

  // Receiver stall pattern: switch between random stall modes
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_run  <= $urandom_range(16, 128);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HALF:  out_stall <= 1'($urandom_range(0, 1));
      default:     out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  always @(posedge clk) begin : check_result
    wrs_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result index %0d status %0d",
                                  out_data.selected_index, out_data.status));
      end else begin
        want = pending_results.pop_front();
        if (out_data.selected_index !== want.selected_index)
          report_mismatch($sformatf("selected_index %0d, expected %0d",
                                    out_data.selected_index, want.selected_index));
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_data.status, want.status));
      end
    end
  end

  function automatic logic [wrs_pkg::W_W-1:0] to_field(input int unsigned v);
    return wrs_pkg::W_W'(v);
  endfunction

  function automatic void clear_particle_set();
    stored_weights = 0;
    total_weight   = 0;
    total_square   = 0;
    resample_armed = 1'b0;
    draw_count     = 0;
    set_closed     = 1'b0;
  endfunction

  // Returns 1 when the item produces a result, written to res
  function automatic bit predict_resample(input wrs_pkg::in_item_t it,
                                          output wrs_pkg::out_item_t res);
    longint unsigned w;
    longint unsigned target;
    int unsigned     k;
    res = '0;
    if (it.operation == wrs_pkg::OP_LOAD) begin
      w = it.weight;
      if (set_closed) clear_particle_set();
      resample_armed = 1'b0;
      // drop weights past the store; a last mark still closes the set
      if (stored_weights < wrs_pkg::MAX_PARTICLES) begin
        total_weight += w;
        total_square += w * w;
        cum_sums[stored_weights] = total_weight;
        stored_weights++;
      end
      if (!it.last) return 1'b0;
      set_closed = 1'b1;
      if (total_weight == 0) begin
        res.status = wrs_pkg::ST_ZERO_SUM;
        return 1'b1;
      end
      if (2 * total_weight * total_weight >= stored_weights * total_square) begin
        res.status = wrs_pkg::ST_EFFICIENT;
        return 1'b1;
      end
      resample_armed = 1'b1;
      draw_count     = 0;
      res.status     = wrs_pkg::ST_RESAMPLE;
      return 1'b1;
    end
    if (!resample_armed || stored_weights == 0 || draw_count >= stored_weights) return 1'b0;
    target = it.uniform * total_weight;
    k = 0;
    while (k < stored_weights - 1 && (cum_sums[k] << wrs_pkg::FRACTION_BITS) < target) k++;
    res.selected_index = k[wrs_pkg::IDX_W-1:0];
    res.status         = wrs_pkg::ST_SELECTED;
    draw_count++;
    return 1'b1;
  endfunction

  function automatic wrs_pkg::in_item_t make_load(input logic [wrs_pkg::W_W-1:0] w,
                                                  input bit is_last);
    wrs_pkg::in_item_t it;
    it.operation = wrs_pkg::OP_LOAD;
    it.weight    = w;
    it.uniform   = to_field($urandom_range(0, W_FIELD_MAX));
    it.last      = is_last;
    return it;
  endfunction

  function automatic wrs_pkg::in_item_t make_draw(input logic [wrs_pkg::W_W-1:0] u);
    wrs_pkg::in_item_t it;
    it.operation = wrs_pkg::OP_DRAW;
    it.weight    = to_field($urandom_range(0, W_FIELD_MAX));
    it.uniform   = u;
    it.last      = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Called at a rising edge; returns at the edge of the transfer or after a gap
  task automatic send_item(input wrs_pkg::in_item_t it);
    wrs_pkg::out_item_t res;
    bit                 has_res;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    has_res = predict_resample(it, res);
    if (has_res) pending_results = {pending_results, res};
    counted_items++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 12);
    end
  endtask

  // Hold the sender until every outstanding result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_TAIL) @(posedge clk);
  endtask

  function automatic logic [wrs_pkg::W_W-1:0] pick_weight(
      input weight_style_t style, input logic [wrs_pkg::W_W-1:0] common);
    case (style)
      W_SKEWED:  return ($urandom_range(0, 3) == 0) ? to_field($urandom_range(0, W_FIELD_MAX))
                                                    : to_field($urandom_range(0, 255));
      W_FULL:    return to_field($urandom_range(0, W_FIELD_MAX));
      W_EQUAL:   return common;
      W_ZERO:    return '0;
      W_SPARSE:  return ($urandom_range(0, 4) == 0) ? to_field($urandom_range(1, 65536)) : '0;
      W_TINY:    return to_field($urandom_range(0, 3));
      default:   return $urandom_range(0, 1) ? W_FIELD_MAX : to_field(65536);
    endcase
  endfunction

  function automatic logic [wrs_pkg::W_W-1:0] pick_uniform();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return to_field(65536);
    if (r == 2) return W_FIELD_MAX;
    if (r <= 4) return to_field($urandom_range(65537, W_FIELD_MAX));
    return to_field($urandom_range(0, 65536));
  endfunction

  task automatic test_directed();
    send_item(make_draw(to_field(65536)));   // unarmed after reset: ignored
    // zero weight at index 0, max field weight
    send_item(make_load('0, 1'b0));
    send_item(make_load(W_FIELD_MAX, 1'b0));
    send_item(make_load(to_field(1), 1'b0));
    send_item(make_load('0, 1'b1));
    send_item(make_draw('0));
    send_item(make_draw(W_FIELD_MAX));       // above 1.0: saturates to N-1
    send_item(make_draw(to_field(65536)));
    send_item(make_draw(to_field(1)));
    send_item(make_draw(to_field(65536)));   // past N draws: ignored
    // single zero weight gives a zero sum, draws stay ignored
    send_item(make_load('0, 1'b1));
    send_item(make_draw(to_field(30000)));
    // equal weights are efficient enough
    send_item(make_load(to_field(65536), 1'b0));
    send_item(make_load(to_field(65536), 1'b1));
    send_item(make_draw(to_field(30000)));
    // a load in the middle of the draws disarms
    send_item(make_load('0, 1'b0));
    send_item(make_load('0, 1'b0));
    send_item(make_load(to_field(1000), 1'b1));
    send_item(make_draw(to_field(40000)));
    send_item(make_load(to_field(500), 1'b0));
    send_item(make_draw(to_field(40000)));
    send_item(make_load(to_field(500), 1'b1));
    drain_results();
  endtask

  // Overfill the store: the last two loads are dropped, the last mark still closes
  task automatic test_full_set();
    int i;
    for (i = 0; i < wrs_pkg::MAX_PARTICLES + 2; i++) begin
      if (i % 8 == 0)
        send_item(make_load(to_field($urandom_range(0, W_FIELD_MAX)),
                            i == wrs_pkg::MAX_PARTICLES + 1));
      else
        send_item(make_load(to_field($urandom_range(0, 7)), i == wrs_pkg::MAX_PARTICLES + 1));
    end
    send_item(make_draw(W_FIELD_MAX));
    send_item(make_draw('0));
    for (i = 0; i < 40; i++) send_item(make_draw(pick_uniform()));
  endtask

  task automatic test_random_sets();
    int                         n;
    int                         i;
    int                         draws;
    int                         stray_at;
    int unsigned                r;
    weight_style_t              style;
    logic [wrs_pkg::W_W-1:0]    common;
    bit                         leave_open;
    while (counted_items < RANDOM_ITEMS) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
      r = $urandom_range(0, 9);
      style  = (r < 4) ? W_SKEWED : weight_style_t'(r - 3);
      common = to_field($urandom_range(0, W_FIELD_MAX));
      leave_open = ($urandom_range(0, 19) == 0);
      // broken sequence: a draw slipped into the load phase
      stray_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : -1;
      if ($urandom_range(0, 14) == 0) send_item(make_draw(pick_uniform()));
      for (i = 0; i < n; i++) begin
        if (i == stray_at) send_item(make_draw(pick_uniform()));
        send_item(make_load(pick_weight(style, common), (i == n - 1) && !leave_open));
      end
      draws = ($urandom_range(0, 4) == 0) ? n + $urandom_range(1, 3) : $urandom_range(0, n);
      if (!leave_open)
        for (i = 0; i < draws; i++) send_item(make_draw(pick_uniform()));
      if ($urandom_range(0, 39) == 0) drain_results();
    end
  endtask

  initial begin
    clear_particle_set();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_full_set();
    test_random_sets();
    drain_results();
    if (error_count == 0) begin
      $display("weight_resampler_with_ess_check regression: pass");
    end else begin
      $display("weight_resampler_with_ess_check regression: fail");
    end
    $finish;
  end

endmodule
